// ----- hdl/stunaf_pkg.sv -----
package stunaf_pkg;

  // Length of the fixed STUN message header that precedes the attributes.
  localparam int HEADER_BYTES = 20;

  localparam int NHA_W = 18;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_HDR,
    PH_PAY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_NOT_FOUND,
    ST_FOUND,
    ST_TRUNCATED
  } status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        payload_end;
    status_t     status;
    logic [15:0] match_length;
  } result_t;

endpackage

// ----- hdl/stun_attribute_finder_core.sv -----
// STUN attribute finder.
// The slave stream carries one message byte per transaction. tuser marks the
// first byte of a message; with it come the total message length and the wanted
// attribute type in tdata. The block skips the fixed header, walks the attribute
// headers and forwards the payload bytes of the first attribute of the wanted
// type on the master stream (tuser low, tlast on the last payload byte). On the
// final byte of each message it sends one status transaction (tuser high) with
// the search outcome and, when found, the payload length.
// Each accepted byte is registered in the input stage, processed there and its
// results are written to a four-entry output queue, from which the master side
// offers them; a stall of the input stage can hold a byte between the two.
// One byte is taken every cycle while the input stage does not stall; the
// final byte of a message may give two results, which the queue absorbs.
// The input stage stalls only while the queue has fewer than two free entries,
// so a stalled receiver holds the sender off once results fill the queue.
// Synchronous reset empties the queue and the input stage and closes any open
// message: bytes without a first-byte mark are then dropped until a new message.
module stun_attribute_finder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // msg_byte[7:0], message_bytes[23:8], wanted_type[39:24]
  input  logic        s_axis_tuser,  // first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // payload_byte[7:0], search_status[9:8],
                                     // match_length[25:10], zero fill above
  output logic        m_axis_tuser,  // result_kind
  output logic        m_axis_tlast   // payload_end
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  // Input stage.
  logic        in_valid;
  logic [39:0] in_data;
  logic        in_first;
  logic        process;

  // Parser state.
  logic [15:0]             byte_position, byte_position_next;
  logic [15:0]             total_length, total_length_next;
  logic [15:0]             target_type, target_type_next;
  logic [stunaf_pkg::NHA_W-1:0] next_header_at, next_header_at_next;
  logic [23:0]             header_shift, header_shift_next;
  logic [15:0]             payload_left, payload_left_next;
  stunaf_pkg::phase_t      parse_phase, parse_phase_next;
  stunaf_pkg::status_t     outcome, outcome_next;
  logic [15:0]             found_length, found_length_next;

  // Values after a possible message start.
  logic [7:0]              b;
  logic [15:0]             cur_bp, cur_tl, cur_tt, cur_pl, cur_fl;
  logic [stunaf_pkg::NHA_W-1:0] cur_nha;
  stunaf_pkg::phase_t      cur_ph, phase_mid;
  stunaf_pkg::status_t     cur_out;
  logic                    active;
  logic                    hdr_last;
  logic [15:0]             hdr_type, hdr_len;
  logic [18:0]             hdr_end, hdr_aligned;
  logic [stunaf_pkg::NHA_W-1:0] hdr_offset;
  logic [15:0]             pl_dec;
  logic                    final_byte;

  // Results of the current byte.
  stunaf_pkg::result_t res0, res1;
  logic [1:0]          n_res;

  // Output queue.
  stunaf_pkg::result_t fifo_mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [PTR_W:0]      count;
  logic                rd_fire;
  stunaf_pkg::result_t head;

  assign process       = in_valid && (count <= (PTR_W+1)'(DEPTH - 2));
  assign s_axis_tready = !in_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data  <= s_axis_tdata;
      in_first <= s_axis_tuser;
    end
  end

  // Start of a message and the phase change at a header boundary.
  always_comb begin
    b = in_data[7:0];
    if (in_first) begin
      cur_bp  = '0;
      cur_tl  = (in_data[23:8] == '0) ? 16'd1 : in_data[23:8];
      cur_tt  = in_data[39:24];
      cur_nha = stunaf_pkg::NHA_W'(stunaf_pkg::HEADER_BYTES);
      cur_pl  = '0;
      cur_ph  = stunaf_pkg::PH_SKIP;
      cur_out = stunaf_pkg::ST_NOT_FOUND;
      cur_fl  = '0;
    end else begin
      cur_bp  = byte_position;
      cur_tl  = total_length;
      cur_tt  = target_type;
      cur_nha = next_header_at;
      cur_pl  = payload_left;
      cur_ph  = parse_phase;
      cur_out = outcome;
      cur_fl  = found_length;
    end

    active = cur_bp < cur_tl;

    phase_mid = cur_ph;
    if (cur_ph == stunaf_pkg::PH_SKIP && {2'b00, cur_bp} == cur_nha) begin
      if ({1'b0, cur_nha} + 19'd4 < {3'b000, cur_tl}) begin
        phase_mid = stunaf_pkg::PH_HDR;
      end else begin
        phase_mid = stunaf_pkg::PH_DONE;
      end
    end

    hdr_offset  = {2'b00, cur_bp} - cur_nha;
    hdr_last    = (phase_mid == stunaf_pkg::PH_HDR) && (hdr_offset == 18'd3);
    hdr_type    = header_shift[23:8];
    hdr_len     = {header_shift[7:0], b};
    hdr_end     = {1'b0, cur_nha} + 19'd4 + {3'b000, hdr_len};
    hdr_aligned = hdr_end + 19'd3;
    pl_dec      = cur_pl - 16'd1;
    final_byte  = ({1'b0, cur_bp} + 17'd1) == {1'b0, cur_tl};
  end

  // Next state.
  always_comb begin
    byte_position_next  = cur_bp;
    total_length_next   = cur_tl;
    target_type_next    = cur_tt;
    next_header_at_next = cur_nha;
    header_shift_next   = header_shift;
    payload_left_next   = cur_pl;
    parse_phase_next    = cur_ph;
    outcome_next        = cur_out;
    found_length_next   = cur_fl;
    if (active) begin
      byte_position_next = cur_bp + 16'd1;
      parse_phase_next   = phase_mid;
      case (phase_mid)
        stunaf_pkg::PH_HDR: begin
          header_shift_next = {header_shift[15:0], b};
          if (hdr_last) begin
            if (hdr_end > {3'b000, cur_tl}) begin
              outcome_next     = stunaf_pkg::ST_TRUNCATED;
              parse_phase_next = stunaf_pkg::PH_DONE;
            end else if (hdr_type == cur_tt) begin
              outcome_next      = stunaf_pkg::ST_FOUND;
              found_length_next = hdr_len;
              payload_left_next = hdr_len;
              parse_phase_next  = (hdr_len == '0) ? stunaf_pkg::PH_DONE
                                                  : stunaf_pkg::PH_PAY;
            end else begin
              next_header_at_next = {hdr_aligned[stunaf_pkg::NHA_W-1:2], 2'b00};
              parse_phase_next    = stunaf_pkg::PH_SKIP;
            end
          end
        end
        stunaf_pkg::PH_PAY: begin
          payload_left_next = pl_dec;
          if (pl_dec == '0) begin
            parse_phase_next = stunaf_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Results of this byte: a payload byte first, then the status on the final byte.
  always_comb begin
    stunaf_pkg::result_t pay_res;
    stunaf_pkg::result_t st_res;
    pay_res.kind         = stunaf_pkg::KIND_PAYLOAD;
    pay_res.payload_byte = b;
    pay_res.payload_end  = (pl_dec == '0);
    pay_res.status       = stunaf_pkg::ST_NOT_FOUND;
    pay_res.match_length = '0;
    st_res.kind          = stunaf_pkg::KIND_STATUS;
    st_res.payload_byte  = '0;
    st_res.payload_end   = 1'b0;
    st_res.status        = outcome_next;
    st_res.match_length  = (outcome_next == stunaf_pkg::ST_FOUND) ? found_length_next : '0;

    res0  = st_res;
    res1  = st_res;
    n_res = 2'd0;
    if (active) begin
      if (phase_mid == stunaf_pkg::PH_PAY) begin
        res0  = pay_res;
        n_res = final_byte ? 2'd2 : 2'd1;
      end else begin
        n_res = final_byte ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      total_length   <= '0;
      target_type    <= '0;
      next_header_at <= stunaf_pkg::NHA_W'(stunaf_pkg::HEADER_BYTES);
      header_shift   <= '0;
      payload_left   <= '0;
      parse_phase    <= stunaf_pkg::PH_SKIP;
      outcome        <= stunaf_pkg::ST_NOT_FOUND;
      found_length   <= '0;
    end else if (process) begin
      byte_position  <= byte_position_next;
      total_length   <= total_length_next;
      target_type    <= target_type_next;
      next_header_at <= next_header_at_next;
      header_shift   <= header_shift_next;
      payload_left   <= payload_left_next;
      parse_phase    <= parse_phase_next;
      outcome        <= outcome_next;
      found_length   <= found_length_next;
    end
  end

  // Output queue: up to two writes and one read per cycle.
  assign rd_fire = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (process && n_res != 2'd0) begin
      fifo_mem[wr_ptr] <= res0;
      if (n_res == 2'd2) begin
        fifo_mem[wr_ptr + PTR_W'(1)] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (process) begin
        wr_ptr <= wr_ptr + PTR_W'(process ? n_res : 2'd0);
      end
      if (rd_fire) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W+1)'(process ? n_res : 2'd0) - (PTR_W+1)'(rd_fire);
    end
  end

  assign head          = fifo_mem[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {6'b000000, head.match_length, head.status, head.payload_byte};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.payload_end;

endmodule
